### src/b2da_pkg.sv
package b2da_pkg;

  // width of the value field on the input port
  localparam int unsigned VALUE_FIELD_W = 32;
  // default conversion width
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned DIGIT_CHAR_W = 6;
  localparam int unsigned BCD_DIGIT_W = 4;

  // ascii '0', kept to the width of the digit field
  localparam logic [DIGIT_CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // double dabble correction
  localparam logic [BCD_DIGIT_W-1:0] BCD_ADJ_LIMIT = 4'd5;
  localparam logic [BCD_DIGIT_W-1:0] BCD_ADJ_ADD = 4'd3;

  // one result word
  typedef struct packed {
    logic [DIGIT_CHAR_W-1:0] digit_char;
    logic                    last_digit;
  } res_t;

  // bits of the value that take part in the conversion
  function automatic int unsigned eff_width(input int unsigned w);
    eff_width = (w < VALUE_FIELD_W) ? w : VALUE_FIELD_W;
  endfunction

  // decimal digits needed for a w-bit unsigned value: floor(w * log10(2)) + 1
  function automatic int unsigned num_digits(input int unsigned w);
    num_digits = (w * 30103) / 100000 + 1;
  endfunction

endpackage

### src/b2da_front.sv
module b2da_front #(
  parameter int unsigned VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          push,
  output logic                                          full,
  input  logic [b2da_pkg::VALUE_FIELD_W-1:0]            value_i,
  output logic                                          item_valid_o,
  input  logic                                          item_ready_i,
  output logic [b2da_pkg::eff_width(VALUE_WIDTH)-1:0]   item_value_o
);
  import b2da_pkg::*;

  localparam int unsigned EffW = eff_width(VALUE_WIDTH);

  logic [EffW-1:0] mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            wr_en, rd_en;

  assign full         = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_value_o = mem_q[rd_ptr_q];

  assign wr_en = push && !full;
  assign rd_en = item_valid_o && item_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_en;
    rd_ptr_d = rd_ptr_q ^ rd_en;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // only the low bits of the field take part
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= value_i[EffW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### src/b2da_back.sv
module b2da_back #(
  parameter int unsigned VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          item_valid_i,
  output logic                                          item_ready_o,
  input  logic [b2da_pkg::eff_width(VALUE_WIDTH)-1:0]   item_value_i,
  output logic                                          res_push_o,
  input  logic                                          res_full_i,
  output b2da_pkg::res_t                                res_o
);
  import b2da_pkg::*;

  localparam int unsigned EffW   = eff_width(VALUE_WIDTH);
  localparam int unsigned NumDig = num_digits(EffW);
  localparam int unsigned BcdW   = NumDig * BCD_DIGIT_W;
  localparam int unsigned CntW   = $clog2(EffW);
  localparam int unsigned IdxW   = $clog2(NumDig);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHIFT = 3'b010,
    ST_EMIT  = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic [EffW-1:0]        bin_q, bin_d;
  logic [BcdW-1:0]        bcd_q, bcd_d;
  logic [BcdW-1:0]        bcd_adj;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic                   started_q, started_d;
  logic [BCD_DIGIT_W-1:0] cur_digit;
  logic                   lead_zero;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NumDig; i++) begin
      if (bcd_q[i*BCD_DIGIT_W +: BCD_DIGIT_W] >= BCD_ADJ_LIMIT) begin
        bcd_adj[i*BCD_DIGIT_W +: BCD_DIGIT_W] =
          bcd_q[i*BCD_DIGIT_W +: BCD_DIGIT_W] + BCD_ADJ_ADD;
      end else begin
        bcd_adj[i*BCD_DIGIT_W +: BCD_DIGIT_W] = bcd_q[i*BCD_DIGIT_W +: BCD_DIGIT_W];
      end
    end
  end

  assign cur_digit = bcd_q[{idx_q, 2'b00} +: BCD_DIGIT_W];
  assign lead_zero = (cur_digit == '0) && !started_q && (idx_q != '0);

  assign item_ready_o     = (state_q == ST_IDLE);
  assign res_o.digit_char = ASCII_ZERO + {{(DIGIT_CHAR_W-BCD_DIGIT_W){1'b0}}, cur_digit};
  assign res_o.last_digit = (idx_q == '0);
  assign res_push_o       = (state_q == ST_EMIT) && !lead_zero && !res_full_i;

  always_comb begin
    state_d   = state_q;
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    started_d = started_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          bin_d   = item_value_i;
          bcd_d   = '0;
          cnt_d   = CntW'(EffW - 1);
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        bcd_d = {bcd_adj[BcdW-2:0], bin_q[EffW-1]};
        bin_d = {bin_q[EffW-2:0], 1'b0};
        if (cnt_q == '0) begin
          idx_d     = IdxW'(NumDig - 1);
          started_d = 1'b0;
          state_d   = ST_EMIT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_EMIT: begin
        if (lead_zero) begin
          idx_d = idx_q - 1'b1;
        end else if (!res_full_i) begin
          started_d = 1'b1;
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    cnt_q <= cnt_d;
    idx_q <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
    end
  end

endmodule

### src/b2da_res_q.sv
module b2da_res_q (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  b2da_pkg::res_t res_i,
  input  logic           pop,
  output logic           empty,
  output b2da_pkg::res_t res_o
);
  import b2da_pkg::*;

  res_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;

  assign full_o = (cnt_q == 2'd2);
  assign empty  = (cnt_q == 2'd0);
  assign res_o  = mem_q[rd_ptr_q];

  assign wr_en = push_i && !full_o;
  assign rd_en = pop && !empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_en;
    rd_ptr_d = rd_ptr_q ^ rd_en;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### src/binary_to_decimal_ascii_unit.sv
// channel | handshake   | payload                       | direction
// --------+-------------+-------------------------------+----------
// value   | push / full | value_i[31:0]                 | in
// digit   | pop / empty | digit_char_o[5:0], last_digit_o | out
//
// one word is accepted, shifted through the double dabble loop once per bit of
// W (W = VALUE_WIDTH, capped at 32), and then each bcd digit position is visited
// msd first while the digits are sent out; leading zeros are skipped, not sent
// reset clears the queue pointers and counts and the sequencer state only
// a two-deep input queue takes new words while the converter is busy, and
// a two-deep result queue lets the converter run on while pop is held low
module binary_to_decimal_ascii_unit #(
  parameter int unsigned VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input word queue
  input  logic                                push,
  output logic                                full,
  input  logic [b2da_pkg::VALUE_FIELD_W-1:0]  value_i,
  // result word queue
  output logic                                empty,
  input  logic                                pop,
  output logic [b2da_pkg::DIGIT_CHAR_W-1:0]   digit_char_o,
  output logic                                last_digit_o
);
  import b2da_pkg::*;

  localparam int unsigned EffW = eff_width(VALUE_WIDTH);

  // front to back: one masked value at a time
  logic            item_valid;
  logic            item_ready;
  logic [EffW-1:0] item_value;

  // back to result queue
  logic res_push;
  logic res_full;
  res_t res_in;
  res_t res_out;

  // front: accepts words and keeps the bits that take part
  b2da_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .value_i      (value_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_value_o (item_value)
  );

  // back: shift-add-3 conversion, then digits out msd first
  b2da_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_value_i (item_value),
    .res_push_o   (res_push),
    .res_full_i   (res_full),
    .res_o        (res_in)
  );

  // result queue towards the consumer
  b2da_res_q u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .full_o (res_full),
    .res_i  (res_in),
    .pop    (pop),
    .empty  (empty),
    .res_o  (res_out)
  );

  assign digit_char_o = res_out.digit_char;
  assign last_digit_o = res_out.last_digit;

endmodule
